@@ rtl/ttlpf_pkg.sv @@
// Package with shared types, constants and helpers for the tile layer pixel fetch.
`default_nettype none
package ttlpf_pkg;
  localparam int VideoHalfwords = 32768;
  localparam int VaddrW = $clog2(VideoHalfwords);
  localparam int LineWidth = 240;
  localparam int PalDepth = 256;
  localparam int QueueDepth = 4;

  localparam logic [1:0] ACT_VWRITE = 2'd0;
  localparam logic [1:0] ACT_PWRITE = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] REG_CTL0 = 3'd0;
  localparam logic [2:0] REG_SCR0 = 3'd4;

  // Classified word passed from front to back.
  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] mem_address;
    logic [15:0] write_value;
    logic [1:0]  layer;
    logic [7:0]  line;
    logic [7:0]  column;
  } cmd_t;

  function automatic logic [31:0] expand_color(input logic [15:0] c);
    logic [4:0] r, g, b;
    r = c[4:0];
    g = c[9:5];
    b = c[14:10];
    return {8'hFF, r, r[4:2], g, g[4:2], b, b[4:2]};
  endfunction
endpackage
`default_nettype wire

@@ rtl/ttlpf_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module ttlpf_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/ttlpf_front.sv @@
// Front end: accepts input words, drops those without effect, queues the rest.
`default_nettype none
module ttlpf_front
  import ttlpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cmd_t        in_cmd,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);
  cmd_t       buf_q [QueueDepth];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       keep, push, pop;

  // Render items off the line and unused actions are dropped here.
  always_comb begin
    keep = (in_cmd.action == ACT_VWRITE) || (in_cmd.action == ACT_PWRITE) ||
           ((in_cmd.action == ACT_RENDER) && ({24'd0, in_cmd.column} < LineWidth));
  end

  assign in_ready = (count != 3'(QueueDepth));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = buf_q[rptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) buf_q[wptr] <= in_cmd;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QueueDepth)) else $error("queue count out of range");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == 3'(QueueDepth)) |-> !in_ready) else $error("full queue accepts");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 3'd1)) else $error("count slip");
`endif
endmodule
`default_nettype wire

@@ rtl/ttlpf_back.sv @@
// Back end: pipelined map, tile and palette fetch, with writes into both memories.
`default_nettype none
module ttlpf_back
  import ttlpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire cmd_t        q_cmd,
  input  wire logic [15:0] ctl [4],
  input  wire logic [17:0] scr [4],
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_color,
  output logic             opaque,
  output logic [7:0]       pal_index
);
  // Pipeline: s1 map read, s2 char read, s3 palette read, s4 output register.
  logic        v1, v2, v3, v4;
  logic        adv;
  logic        stall;

  // Stage 0 address math.
  logic [15:0] c0;
  logic [8:0]  px, py;
  logic [5:0]  tx, ty;
  logic [1:0]  sect;
  logic [16:0] map_byte;
  logic        is_render, vwr;

  // Stage 1 registers.
  logic [2:0]  pxl1, pyl1;
  logic [15:0] c1;
  // Stage 1 logic.
  logic [15:0] entry;
  logic [2:0]  fx, fy;
  logic [16:0] chr_byte;
  // Stage 2 registers.
  logic        odd2, nib2, w82;
  logic [3:0]  bank2;
  logic [15:0] half;
  logic [7:0]  byte2, idx2;
  // Stage 3 registers.
  logic [7:0]  idx3;
  logic [15:0] pal;

  // Palette write carried along to the palette read stage.
  logic        pw1, pw2;
  logic [7:0]  pa1, pa2;
  logic [15:0] pd1, pd2;

  logic [VaddrW-1:0] vaddr;

  assign stall   = v4 && !out_ready;
  assign adv     = !stall;
  assign q_ready = adv;
  assign out_valid = v4;

  always_comb begin
    c0 = ctl[q_cmd.layer];
    px = 9'(q_cmd.column) + scr[q_cmd.layer][8:0];
    py = 9'(q_cmd.line) + scr[q_cmd.layer][17:9];
    tx = {px[8] & c0[14], px[7:3]};
    ty = {py[8] & c0[15], py[7:3]};
    sect = c0[14] ? {ty[5], tx[5]} : {1'b0, ty[5] | tx[5]};
    if (!c0[14]) sect = {1'b0, 1'b0} + 2'(ty[5]) + 2'(tx[5]);
    map_byte = 17'({c0[12:8], 11'd0}) + 17'({sect, 11'd0}) +
               17'({ty[4:0], tx[4:0], 1'b0});
    is_render = q_valid && (q_cmd.action == ACT_RENDER);
    vwr = q_valid && adv && (q_cmd.action == ACT_VWRITE);
    vaddr = vwr ? q_cmd.mem_address[VaddrW-1:0] : VaddrW'(map_byte >> 1);
  end

  // The video memory is read twice per pixel, so two banks hold the same data.
  ttlpf_ram #(.Width(16), .Depth(VideoHalfwords)) u_map_ram (
    .clk, .we(vwr), .waddr(q_cmd.mem_address[VaddrW-1:0]), .wdata(q_cmd.write_value),
    .re(adv), .raddr(vaddr), .rdata(entry));

  always_comb begin
    fx = entry[10] ? ~pxl1 : pxl1;
    fy = entry[11] ? ~pyl1 : pyl1;
    chr_byte = c1[7] ? 17'({c1[3:2], 14'd0}) + 17'({entry[9:0], fy, fx})
                     : 17'({c1[3:2], 14'd0}) + 17'({entry[9:0], fy, fx[2:1]});
  end

  ttlpf_ram #(.Width(16), .Depth(VideoHalfwords)) u_chr_ram (
    .clk, .we(vwr), .waddr(q_cmd.mem_address[VaddrW-1:0]), .wdata(q_cmd.write_value),
    .re(adv), .raddr(VaddrW'(chr_byte >> 1)), .rdata(half));

  always_comb begin
    byte2 = odd2 ? half[15:8] : half[7:0];
    if (w82) idx2 = byte2;
    else begin
      idx2 = {4'd0, nib2 ? byte2[7:4] : byte2[3:0]};
      if (idx2 != 8'd0) idx2 = idx2 + {bank2, 4'd0};
    end
  end

  // Palette writes land at the read stage, so they stay in order with renders.
  ttlpf_ram #(.Width(16), .Depth(PalDepth)) u_pal_ram (
    .clk, .we(pw2 && adv), .waddr(pa2), .wdata(pd2),
    .re(adv), .raddr(idx2), .rdata(pal));

  // Pipeline control and sideband registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      pw1 <= 1'b0;
      pw2 <= 1'b0;
    end else if (adv) begin
      v1 <= is_render;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      pw1 <= q_valid && (q_cmd.action == ACT_PWRITE);
      pw2 <= pw1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxl1 <= px[2:0];
      pyl1 <= py[2:0];
      c1 <= c0;
      pa1 <= q_cmd.mem_address[7:0];
      pd1 <= q_cmd.write_value;
      pa2 <= pa1;
      pd2 <= pd1;
      odd2 <= chr_byte[0];
      nib2 <= fx[0];
      w82 <= c1[7];
      bank2 <= entry[15:12];
      idx3 <= idx2;
      if (v3) begin
        opaque <= (idx3 != 8'd0);
        pal_index <= idx3;
        pixel_color <= (idx3 != 8'd0) ? expand_color(pal) : 32'd0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_ready) |=> (v4 && $stable(pixel_color))) else $error("result lost");
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_ready) |-> !q_ready) else $error("pipe moves on stall");
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (opaque == (pal_index != 8'd0))) else $error("opaque mismatch");
`endif
endmodule
`default_nettype wire

@@ rtl/text_tile_layer_pixel_fetch_core.sv @@
// Top level: configuration registers, front queue and back fetch pipeline.
// A render word passes through the queue, the map, char and palette reads and the
// output register. Throughput: one word per cycle unless out_ready stalls the pipe;
// the four-stage pipe plus a four-entry queue decouple input and output.
// Reset clears configuration and pipeline control; memories stay undefined.
`default_nettype none
module text_tile_layer_pixel_fetch_core
  import ttlpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [14:0] mem_address,
  input  wire logic [15:0] write_value,
  input  wire logic [1:0]  layer,
  input  wire logic [7:0]  line,
  input  wire logic [7:0]  column,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_color,
  output logic             opaque,
  output logic [7:0]       pal_index,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);
  logic [15:0] ctl [4];
  logic [17:0] scr [4];
  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_ready;

  assign cfg_ready = 1'b1;
  assign in_cmd = '{action: action, mem_address: mem_address, write_value: write_value,
                    layer: layer, line: line, column: column};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        ctl[i] <= '0;
        scr[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index < REG_SCR0) ctl[cfg_index[1:0]] <= cfg_data[15:0];
      else scr[cfg_index[1:0]] <= cfg_data;
    end
  end

  ttlpf_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd, .q_valid, .q_ready, .q_cmd);

  ttlpf_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .ctl, .scr, .out_valid, .out_ready,
    .pixel_color, .opaque, .pal_index);

`ifndef ASSERT_OFF
  a_ctl_base: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_index == REG_CTL0) |=> (ctl[0] == $past(cfg_data[15:0])))
    else $error("control write lost");
  a_scr_base: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_index == REG_SCR0) |=> (scr[0] == $past(cfg_data)))
    else $error("scroll write lost");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");
`endif
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the tile layer pixel fetch core.
`default_nettype none
module testbench;
  import ttlpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        opaque;
    logic [7:0]  pal_index;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] mem_address;
    logic [15:0] write_value;
    logic [1:0]  layer;
    logic [7:0]  line;
    logic [7:0]  column;
    logic        known;
    pixel_t      pixel;
  } row_t;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_VWRITE;
  logic [14:0] mem_address = '0;
  logic [15:0] write_value = '0;
  logic [1:0]  layer = '0;
  logic [7:0]  line = '0;
  logic [7:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_color;
  logic        opaque;
  logic [7:0]  pal_index;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Shadow copy of the block's memories and registers.
  logic [15:0] vram_shadow [VideoHalfwords];
  logic [15:0] pal_shadow [PalDepth];
  logic [15:0] ctl_shadow [4];
  logic [17:0] scroll_shadow [4];
  bit          vram_written [VideoHalfwords];
  bit          pal_written [PalDepth];

  pixel_t pending_pixels [$];
  int errors = 0;
  int pixels_checked = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  text_tile_layer_pixel_fetch_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] vram_byte(input logic [15:0] byte_addr);
    logic [15:0] w;
    w = vram_shadow[byte_addr[15:1]];
    return byte_addr[0] ? w[15:8] : w[7:0];
  endfunction

  function automatic logic [31:0] expand_rgb(input logic [15:0] c);
    logic [7:0] r, g, b;
    r = {c[4:0], c[4:2]};
    g = {c[9:5], c[9:7]};
    b = {c[14:10], c[14:12]};
    return {8'hFF, r, g, b};
  endfunction

  // Computes the pixel a render word produces; returns 0 when no pixel is due.
  // When the word would read a memory entry not yet written, gap is set and
  // fill holds a write word for that entry.
  function automatic bit predict_pixel(input logic [1:0] lay, input logic [7:0] ln,
                                       input logic [7:0] col, output pixel_t pix,
                                       output bit gap, output row_t fill);
    logic [15:0] ctl, entry, map_byte_addr, char_addr;
    logic [17:0] scr;
    logic [8:0]  px, py;
    logic [5:0]  tx, ty;
    logic [2:0]  fx, fy;
    logic [1:0]  section;
    logic [7:0]  bits, idx;
    pix = '0;
    gap = 1'b0;
    fill = '0;
    fill.write_value = 16'($urandom());
    if (col >= LineWidth) return 0;
    ctl = ctl_shadow[lay];
    scr = scroll_shadow[lay];
    px = 9'(col + scr[8:0]);
    py = 9'(ln + scr[17:9]);
    tx = ctl[14] ? px[8:3] : {1'b0, px[7:3]};
    ty = ctl[15] ? py[8:3] : {1'b0, py[7:3]};
    section = ctl[14] ? {ty[5], tx[5]} : {1'b0, ty[5] | tx[5]};
    if (!ctl[14]) section = {1'b0, 1'b0} + ty[5] + tx[5];
    map_byte_addr = 16'(ctl[12:8] * 16'h800 + section * 16'h800 +
                        (ty[4:0] * 32 + tx[4:0]) * 2);
    if (!vram_written[map_byte_addr[15:1]]) begin
      gap = 1'b1;
      fill.action = ACT_VWRITE;
      fill.mem_address = map_byte_addr[15:1];
      return 1;
    end
    entry = vram_shadow[map_byte_addr[15:1]];
    fx = entry[10] ? 3'd7 - px[2:0] : px[2:0];
    fy = entry[11] ? 3'd7 - py[2:0] : py[2:0];
    if (ctl[7])
      char_addr = 16'(ctl[3:2] * 16'h4000 + entry[9:0] * 64 + fy * 8 + fx);
    else
      char_addr = 16'(ctl[3:2] * 16'h4000 + entry[9:0] * 32 + fy * 4 + fx[2:1]);
    if (!vram_written[char_addr[15:1]]) begin
      gap = 1'b1;
      fill.action = ACT_VWRITE;
      fill.mem_address = char_addr[15:1];
      return 1;
    end
    bits = vram_byte(char_addr);
    if (ctl[7]) begin
      idx = bits;
    end else begin
      idx = fx[0] ? {4'd0, bits[7:4]} : {4'd0, bits[3:0]};
      if (idx != 0) idx = 8'(idx + entry[15:12] * 16);
    end
    if (idx != 0 && !pal_written[idx]) begin
      gap = 1'b1;
      fill.action = ACT_PWRITE;
      fill.mem_address = 15'(idx);
      return 1;
    end
    if (idx != 0) begin
      pix.pixel_color = expand_rgb(pal_shadow[idx]);
      pix.opaque = 1'b1;
      pix.pal_index = idx;
    end
    return 1;
  endfunction

  // Offers one word, waits for its acceptance and updates the shadow state.
  task automatic offer_word(input row_t r);
    pixel_t pix;
    row_t   fill;
    bit     gap;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.action;
    mem_address <= r.mem_address;
    write_value <= r.write_value;
    layer <= r.layer;
    line <= r.line;
    column <= r.column;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    case (r.action)
      ACT_VWRITE: begin
        vram_shadow[r.mem_address] = r.write_value;
        vram_written[r.mem_address] = 1'b1;
      end
      ACT_PWRITE: begin
        pal_shadow[r.mem_address[7:0]] = r.write_value;
        pal_written[r.mem_address[7:0]] = 1'b1;
      end
      ACT_RENDER: begin
        if (predict_pixel(r.layer, r.line, r.column, pix, gap, fill))
          pending_pixels.push_back(r.known ? r.pixel : pix);
      end
      default: ;
    endcase
  endtask

  // Sends a word; unknown render words first get writes to unwritten entries they read.
  task automatic send_word(input row_t r);
    pixel_t pix;
    row_t   fill;
    bit     gap;
    if (r.action == ACT_RENDER && !r.known) begin
      void'(predict_pixel(r.layer, r.line, r.column, pix, gap, fill));
      while (gap) begin
        offer_word(fill);
        void'(predict_pixel(r.layer, r.line, r.column, pix, gap, fill));
      end
    end
    offer_word(r);
  endtask

  // Writes one register once all pixels have drained and the pipe is empty.
  task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < REG_SCR0) ctl_shadow[idx[1:0]] = data[15:0];
    else scroll_shadow[idx[1:0]] = data;
  endtask

  task automatic write_all_regs(input int pick);
    for (int i = 0; i < 4; i++) begin
      case (pick)
        0: write_reg(REG_CTL0 + 3'(i), 18'h0FFFF);
        1: write_reg(REG_CTL0 + 3'(i), 18'h0);
        default: write_reg(REG_CTL0 + 3'(i), 18'($urandom_range(16'hFFFF)));
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      case (pick)
        0: write_reg(REG_SCR0 + 3'(i), 18'h3FFFF);
        1: write_reg(REG_SCR0 + 3'(i), 18'h0);
        default: write_reg(REG_SCR0 + 3'(i), 18'($urandom_range(18'h3FFFF)));
      endcase
    end
  endtask

  function automatic row_t random_row();
    row_t r;
    int pick;
    r = '0;
    pick = $urandom_range(99);
    r.action = pick < 70 ? ACT_RENDER : pick < 94 ? ACT_VWRITE :
               pick < 99 ? ACT_PWRITE : ACT_NONE;
    r.mem_address = 15'($urandom());
    r.write_value = 16'($urandom());
    r.layer = 2'($urandom());
    r.line = 8'($urandom());
    r.column = $urandom_range(99) < 90 ? 8'($urandom_range(LineWidth - 1)) : 8'($urandom());
    return r;
  endfunction

  // Result checker and receiver stall control, including the long hold-off.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        $error("pixel word arrived with nothing expected");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_color !== want.pixel_color) begin
          $error("pixel_color expected %h got %h", want.pixel_color, pixel_color);
          errors++;
        end
        if (opaque !== want.opaque) begin
          $error("opaque expected %b got %b", want.opaque, opaque);
          errors++;
        end
        if (pal_index !== want.pal_index) begin
          $error("pal_index expected %h got %h", want.pal_index, pal_index);
          errors++;
        end
      end
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t dir_rows [$];
    row_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      ctl_shadow[i] = '0;
      scroll_shadow[i] = '0;
    end

    // Directed words with registers at reset values; the map entry of pixel 0
    // is video halfword 0 and tile 1 starts at halfword 16.
    dir_rows = '{
      '{ACT_VWRITE, 15'h0000, 16'h0000, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd0, 8'd0, 8'd0, 1'b1, '0},
      '{ACT_PWRITE, 15'h7F01, 16'hFFFF, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_VWRITE, 15'h0000, 16'h0001, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_VWRITE, 15'h0010, 16'h0021, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd0, 8'd0, 8'd0, 1'b1,
        '{32'hFFFFFFFF, 1'b1, 8'd1}},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd1, 8'd0, 8'd1, 1'b0, '0},
      '{ACT_VWRITE, 15'h0000, 16'h0401, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd2, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_VWRITE, 15'h0000, 16'h0801, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd3, 8'd0, 8'd2, 1'b0, '0},
      '{ACT_VWRITE, 15'h0000, 16'hFC01, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd0, 8'd0, 8'd3, 1'b0, '0},
      '{ACT_NONE,   15'h7FFF, 16'hFFFF, 2'd3, 8'd255, 8'd255, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd0, 8'd0, 8'd240, 1'b0, '0},
      '{ACT_RENDER, 15'h7FFF, 16'hFFFF, 2'd3, 8'd255, 8'd255, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd1, 8'd255, 8'd239, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd2, 8'd159, 8'd0, 1'b0, '0},
      '{ACT_VWRITE, 15'h7FFF, 16'hFFFF, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_PWRITE, 15'h00FF, 16'h8000, 2'd0, 8'd0, 8'd0, 1'b0, '0},
      '{ACT_RENDER, 15'h0000, 16'h0000, 2'd0, 8'd7, 8'd7, 1'b0, '0}
    };
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // Random phases, each under its own register setting and one of four idling patterns.
    for (int phase = 0; phase < 6; phase++) begin
      int phase_end;
      int n;
      write_all_regs(phase == 0 ? 0 : phase == 5 ? 1 : 2);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      phase_end = words_sent + 310;
      n = 0;
      while (words_sent < phase_end) begin
        if (phase == 1 && n == 20) begin
          send_idle_pct = 0;
          hold_requests++;
        end
        if (phase == 1 && n == 100) send_idle_pct = 50;
        r = random_row();
        send_word(r);
        n++;
      end
    end
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d words, checked %0d pixels over six register settings", words_sent,
             pixels_checked);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
